### rtl/hkv_pkg.sv
// ----------------------------------------------------------------------------
// Hashed key/value store package
// Shared widths, action codes, sequencer states and entry layout.
// ----------------------------------------------------------------------------
package hkv_pkg;

   // Field widths of one item.
   localparam int ACT_W = 2;
   localparam int KEY_W = 31;
   localparam int VAL_W = 32;

   // Default table geometry.
   localparam int DEF_BUCKETS = 16;
   localparam int DEF_WAYS    = 4;

   // Action codes of an input item.
   typedef enum logic [ACT_W-1:0] {
      ACT_READ  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_ERASE = 2'd2
   } action_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_READ,
      ST_CHECK,
      ST_FINISH
   } state_type;

   // One slot of the table as held in memory.
   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } entry_type;

   // Status of the remainder unit toward the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } mod_status_type;

endpackage

### rtl/hashed_key_value_store.sv
// ----------------------------------------------------------------------------
// Hashed key/value store
// Bucketed table of key/value pairs with read-or-create, write and erase.
// ----------------------------------------------------------------------------
// A key lives in bucket (key mod BUCKETS), which has WAYS slots held in one
// RAM. After reset a clearing pass writes every slot empty, one slot per
// cycle, so the block stalls requests until the pass ends. Each item then
// goes through an accept step, a probe of every way in turn (a RAM read and
// then a key compare in the single shared comparator), and a step to write
// back and post the result. When BUCKETS is not a power of two, the bucket
// number comes from a reciprocal-multiply remainder unit ahead of the probe.
// The result sits in an output register, so a new item may be taken while
// it waits, but that item's write back waits until the result is taken.
// ----------------------------------------------------------------------------
module hashed_key_value_store #(
   parameter int BUCKETS = hkv_pkg::DEF_BUCKETS,
   parameter int WAYS    = hkv_pkg::DEF_WAYS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [hkv_pkg::ACT_W-1:0]        req_action,
   input  logic [hkv_pkg::KEY_W-1:0]        req_lookup_key,
   input  logic signed [hkv_pkg::VAL_W-1:0] req_write_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [hkv_pkg::VAL_W-1:0] rsp_read_value,
   output logic                             rsp_key_found,
   output logic                             rsp_status
);

   localparam int  SLOTS    = BUCKETS * WAYS;
   localparam int  ADDR_W   = $clog2(SLOTS);
   localparam int  BKT_W    = $clog2(BUCKETS);
   localparam int  WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int  ENTRY_W  = $bits(hkv_pkg::entry_type);
   localparam bit  IS_POW2  = ((BUCKETS & (BUCKETS - 1)) == 0);

   hkv_pkg::state_type       state_ff, state_in;
   logic [ADDR_W-1:0]        clr_ff, clr_in;
   logic [WAY_W-1:0]         way_ff, way_in;
   logic [BKT_W-1:0]         bucket_ff, bucket_in;
   hkv_pkg::action_type      act_ff, act_in;
   logic [hkv_pkg::KEY_W-1:0] key_ff, key_in;
   logic [hkv_pkg::VAL_W-1:0] wval_ff, wval_in;
   logic                     hit_ff, hit_in;
   logic                     free_ff, free_in;
   logic [WAY_W-1:0]         hit_way_ff, hit_way_in;
   logic [WAY_W-1:0]         free_way_ff, free_way_in;
   logic [hkv_pkg::VAL_W-1:0] hit_val_ff, hit_val_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [hkv_pkg::VAL_W-1:0] rsp_value_ff, rsp_value_in;
   logic                     rsp_found_ff, rsp_found_in;
   logic                     rsp_status_ff, rsp_status_in;

   logic                     req_accept;
   logic                     rsp_accept;
   logic                     mod_start;
   hkv_pkg::mod_status_type  mod_status;
   logic [BKT_W-1:0]         mod_rem;
   logic [ADDR_W-1:0]        base_addr;
   logic                     ram_wr_en;
   logic [ADDR_W-1:0]        ram_wr_addr;
   hkv_pkg::entry_type       ram_wr_entry;
   logic                     ram_rd_en;
   logic [ADDR_W-1:0]        ram_rd_addr;
   logic [ENTRY_W-1:0]       ram_rd_data;
   hkv_pkg::entry_type       rd_entry;
   logic                     key_match;

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;
   assign mod_start  = req_accept && !IS_POW2;
   assign base_addr  = ADDR_W'(bucket_ff) * ADDR_W'(WAYS);
   assign rd_entry   = hkv_pkg::entry_type'(ram_rd_data);

   // Shared key comparator, used once per probed way.
   assign key_match  = rd_entry.valid && (rd_entry.key == key_ff);

   hkv_bucket_mod #(
      .BUCKETS (BUCKETS)
   ) u_bucket_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (req_lookup_key),
      .status    (mod_status),
      .remainder (mod_rem)
   );

   hkv_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_table_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ENTRY_W'(ram_wr_entry)),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Sequencer: next state, probe bookkeeping, write back and result.
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      way_in        = way_ff;
      bucket_in     = bucket_ff;
      act_in        = act_ff;
      key_in        = key_ff;
      wval_in       = wval_ff;
      hit_in        = hit_ff;
      free_in       = free_ff;
      hit_way_in    = hit_way_ff;
      free_way_in   = free_way_ff;
      hit_val_in    = hit_val_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      req_stall     = 1'b1;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = clr_ff;
      ram_wr_entry  = '0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = base_addr + ADDR_W'(way_ff);

      if (rsp_accept) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         hkv_pkg::ST_CLEAR: begin
            // Write every slot empty after reset.
            ram_wr_en = 1'b1;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(SLOTS - 1)) begin
               state_in = hkv_pkg::ST_IDLE;
            end
         end
         hkv_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               act_in    = hkv_pkg::action_type'(req_action);
               key_in    = req_lookup_key;
               wval_in   = req_write_value;
               bucket_in = req_lookup_key[BKT_W-1:0];
               way_in    = '0;
               hit_in    = 1'b0;
               free_in   = 1'b0;
               state_in  = IS_POW2 ? hkv_pkg::ST_READ : hkv_pkg::ST_MOD;
            end
         end
         hkv_pkg::ST_MOD: begin
            if (mod_status.done) begin
               bucket_in = mod_rem;
               state_in  = hkv_pkg::ST_READ;
            end
         end
         hkv_pkg::ST_READ: begin
            ram_rd_en = 1'b1;
            state_in  = hkv_pkg::ST_CHECK;
         end
         hkv_pkg::ST_CHECK: begin
            // Note the first matching way and the first free way.
            if (rd_entry.valid) begin
               if (key_match && !hit_ff) begin
                  hit_in     = 1'b1;
                  hit_way_in = way_ff;
                  hit_val_in = rd_entry.value;
               end
            end else if (!free_ff) begin
               free_in     = 1'b1;
               free_way_in = way_ff;
            end
            if (way_ff == WAY_W'(WAYS - 1)) begin
               state_in = hkv_pkg::ST_FINISH;
            end else begin
               way_in   = way_ff + 1'b1;
               state_in = hkv_pkg::ST_READ;
            end
         end
         hkv_pkg::ST_FINISH: begin
            // Wait until the output register is free, then commit.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_value_in       = '0;
               rsp_found_in       = hit_ff;
               rsp_status_in      = 1'b0;
               ram_wr_entry.valid = 1'b1;
               ram_wr_entry.key   = key_ff;
               ram_wr_entry.value = wval_ff;
               ram_wr_addr        = base_addr + ADDR_W'(hit_way_ff);
               unique case (act_ff)
                  hkv_pkg::ACT_READ: begin
                     if (hit_ff) begin
                        rsp_value_in = hit_val_ff;
                     end else if (free_ff) begin
                        ram_wr_en          = 1'b1;
                        ram_wr_addr        = base_addr + ADDR_W'(free_way_ff);
                        ram_wr_entry.value = '0;
                     end else begin
                        rsp_status_in = 1'b1;
                     end
                  end
                  hkv_pkg::ACT_WRITE: begin
                     if (hit_ff) begin
                        ram_wr_en    = 1'b1;
                        rsp_value_in = wval_ff;
                     end else if (free_ff) begin
                        ram_wr_en    = 1'b1;
                        ram_wr_addr  = base_addr + ADDR_W'(free_way_ff);
                        rsp_value_in = wval_ff;
                     end else begin
                        rsp_status_in = 1'b1;
                     end
                  end
                  hkv_pkg::ACT_ERASE: begin
                     ram_wr_en          = hit_ff;
                     ram_wr_entry.valid = 1'b0;
                  end
                  default: begin
                     // Unused action code: no change, empty result.
                     rsp_found_in = 1'b0;
                  end
               endcase
               state_in = hkv_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hkv_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hkv_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      way_ff        <= way_in;
      bucket_ff     <= bucket_in;
      act_ff        <= act_in;
      key_ff        <= key_in;
      wval_ff       <= wval_in;
      hit_way_ff    <= hit_way_in;
      free_way_ff   <= free_way_in;
      hit_val_ff    <= hit_val_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_key_found  = rsp_found_ff;
   assign rsp_status     = rsp_status_ff;

   // A refused key was never found and reads as zero.
   a_full_result : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (!rsp_key_found && (rsp_read_value == '0)))
      else $error("bucket-full result carries a found flag or a value");

   // No item is taken while the table is being cleared.
   a_no_accept_in_clear : assert property (@(posedge clock) disable iff (reset)
      (state_ff == hkv_pkg::ST_CLEAR) |-> req_stall)
      else $error("request accepted during clearing pass");

   // An accepted item keeps the block busy in the following cycle.
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("request channel open right after an accept");

   // A result is only posted from the commit step.
   a_result_from_finish : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == hkv_pkg::ST_FINISH))
      else $error("result raised outside the commit step");

endmodule

### rtl/hkv_ram.sv
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hkv_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/hkv_bucket_mod.sv
// ----------------------------------------------------------------------------
// Bucket remainder unit
// Computes key mod BUCKETS with a rounded-up reciprocal.
// ----------------------------------------------------------------------------
module hkv_bucket_mod #(
   parameter int BUCKETS = hkv_pkg::DEF_BUCKETS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [hkv_pkg::KEY_W-1:0]     dividend,
   output hkv_pkg::mod_status_type       status,
   output logic [$clog2(BUCKETS)-1:0]    remainder
);

   localparam int BKT_W  = $clog2(BUCKETS);
   localparam int RCP_W  = hkv_pkg::KEY_W + 1;
   localparam int SHIFT  = hkv_pkg::KEY_W + BKT_W;
   localparam int PROD_W = hkv_pkg::KEY_W + RCP_W;

   // Rounded-up reciprocal; the shifted product gives the exact quotient for
   // every key of KEY_W bits.
   localparam longint unsigned RCP_FULL =
      ((64'd1 << SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
   localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_FULL);

   logic [1:0]                    stage_ff, stage_in;
   logic [hkv_pkg::KEY_W-1:0]     div_ff, div_in;
   logic [BKT_W-1:0]              quot_ff, quot_in;
   logic [PROD_W-1:0]             product;

   // Multiply by the reciprocal and keep the quotient's low bits.
   always_comb begin
      product  = PROD_W'(div_ff) * PROD_W'(RCP);
      quot_in  = product[SHIFT +: BKT_W];
      div_in   = start ? dividend : div_ff;
      stage_in = {stage_ff[0], start};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff  <= div_in;
      quot_ff <= quot_in;
   end

   // From the registered quotient: the remainder is below 2**BKT_W, so the low bits suffice.
   assign status.busy = |stage_ff;
   assign status.done = stage_ff[1];
   assign remainder   = div_ff[BKT_W-1:0] - quot_ff * BKT_W'(BUCKETS);

endmodule

### verif/hkv_access_checker.sv
// ----------------------------------------------------------------------------
// Hashed key/value store access checker
// Watches both channels, keeps its own copy of the bucketed table, predicts
// the result of every accepted item and compares each returned item in order.
// ----------------------------------------------------------------------------
module hkv_access_checker #(
   parameter int BUCKETS = hkv_pkg::DEF_BUCKETS,
   parameter int WAYS    = hkv_pkg::DEF_WAYS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic [hkv_pkg::ACT_W-1:0]        req_action,
   input  logic [hkv_pkg::KEY_W-1:0]        req_lookup_key,
   input  logic signed [hkv_pkg::VAL_W-1:0] req_write_value,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic signed [hkv_pkg::VAL_W-1:0] rsp_read_value,
   input  logic                             rsp_key_found,
   input  logic                             rsp_status,
   output int                               failures,
   output int                               pending,
   output int                               checked_count,
   output int                               hit_count,
   output int                               refused_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ACT_W      = hkv_pkg::ACT_W;
   localparam int KEY_W      = hkv_pkg::KEY_W;
   localparam int VAL_W      = hkv_pkg::VAL_W;
   localparam int SLOTS      = BUCKETS * WAYS;
   localparam int REPORT_MAX = 10;

   // One predicted result, with the key kept for the report.
   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
      logic             found;
      logic             refused;
   } access_result_type;

   // Shadow copy of the table.
   logic             slot_used  [SLOTS];
   logic [KEY_W-1:0] slot_key   [SLOTS];
   logic [VAL_W-1:0] slot_value [SLOTS];

   access_result_type results_due[$];
   int                mismatches = 0;
   int                reported   = 0;

   // Apply one access to the shadow table and return what the block must report.
   function automatic access_result_type apply_access(logic [ACT_W-1:0] act,
                                                      logic [KEY_W-1:0] key,
                                                      logic [VAL_W-1:0] wval);
      access_result_type res;
      int                base;
      int                hit_slot;
      int                free_slot;
      int                s;
      base      = int'(key % BUCKETS) * WAYS;
      hit_slot  = -1;
      free_slot = -1;
      res       = '0;
      res.key   = key;
      for (int w = 0; w < WAYS; w++) begin
         s = base + w;
         if (slot_used[s]) begin
            if (hit_slot < 0 && slot_key[s] == key) hit_slot = s;
         end else if (free_slot < 0) begin
            free_slot = s;
         end
      end
      case (act) inside
         hkv_pkg::ACT_READ, hkv_pkg::ACT_WRITE: begin
            res.found = (hit_slot >= 0);
            s = hit_slot;
            // A new key takes the lowest free way of its bucket.
            if (s < 0 && free_slot >= 0) begin
               s              = free_slot;
               slot_used[s]   = 1'b1;
               slot_key[s]    = key;
               slot_value[s]  = '0;
            end
            if (s < 0) begin
               res.refused = 1'b1;
            end else begin
               if (act == hkv_pkg::ACT_WRITE) slot_value[s] = wval;
               res.value = slot_value[s];
            end
         end
         hkv_pkg::ACT_ERASE: begin
            res.found = (hit_slot >= 0);
            if (hit_slot >= 0) slot_used[hit_slot] = 1'b0;
         end
         default: begin
            // Unused action code: nothing changes and the result is all zero.
         end
      endcase
      return res;
   endfunction

   // Compare returned items first, then queue the prediction for a new item.
   always @(posedge clock) begin
      access_result_type want;
      if (reset) begin
         for (int s = 0; s < SLOTS; s++) slot_used[s] = 1'b0;
         results_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (results_due.size() == 0) begin
               mismatches++;
               if (reported < REPORT_MAX) begin
                  reported++;
                  $display("%0t: result item with none expected: value %h found %b status %b",
                           $realtime, rsp_read_value, rsp_key_found, rsp_status);
               end
            end else begin
               want = results_due.pop_front();
               checked_count <= checked_count + 1;
               if (want.found) hit_count <= hit_count + 1;
               if (want.refused) refused_count <= refused_count + 1;
               if (rsp_read_value !== want.value || rsp_key_found !== want.found ||
                   rsp_status !== want.refused) begin
                  mismatches++;
                  if (reported < REPORT_MAX) begin
                     reported++;
                     $display("%0t: key %h expected value %h found %b status %b",
                              $realtime, want.key, want.value, want.found, want.refused);
                     $display("%0t: key %h got      value %h found %b status %b",
                              $realtime, want.key, rsp_read_value, rsp_key_found,
                              rsp_status);
                  end
               end
            end
         end
         if (req_valid && !req_stall)
            results_due.push_back(apply_access(req_action, req_lookup_key,
                                               req_write_value));
      end
      failures <= mismatches;
      pending  <= results_due.size();
   end

endmodule

### verif/tb_hashed_key_value_store.sv
// ----------------------------------------------------------------------------
// Hashed key/value store testbench
// Drives directed corner accesses and four phases of random traffic against
// a small key pool so that hits, inserts, erases and full buckets all occur,
// with random idling on both channels and one long result hold-off.
// ----------------------------------------------------------------------------
module tb_hashed_key_value_store;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ACT_W       = hkv_pkg::ACT_W;
   localparam int KEY_W       = hkv_pkg::KEY_W;
   localparam int VAL_W       = hkv_pkg::VAL_W;
   localparam int BUCKETS     = hkv_pkg::DEF_BUCKETS;
   localparam int WAYS        = hkv_pkg::DEF_WAYS;
   localparam int KEY_POOL    = 24;
   localparam int PHASE_ITEMS = 100;
   localparam int HOLD_CYCLES = 80;

   // Action code that the block does not define.
   localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

   logic                    clock           = 1'b0;
   logic                    reset           = 1'b1;
   logic                    req_valid       = 1'b0;
   logic                    req_stall;
   logic [ACT_W-1:0]        req_action      = hkv_pkg::ACT_READ;
   logic [KEY_W-1:0]        req_lookup_key  = '0;
   logic signed [VAL_W-1:0] req_write_value = '0;
   logic                    rsp_valid;
   logic                    rsp_stall       = 1'b0;
   logic signed [VAL_W-1:0] rsp_read_value;
   logic                    rsp_key_found;
   logic                    rsp_status;

   int failures;
   int pending;
   int checked_count;
   int hit_count;
   int refused_count;

   int idle_pct      = 0;
   int stall_pct     = 0;
   int hold_requests = 0;
   int holds_served  = 0;
   int hold_left     = 0;
   int issued        = 0;

   logic [KEY_W-1:0] key_pool [KEY_POOL];
   logic [VAL_W-1:0] edge_values [4] = '{32'h0000_0000, 32'hFFFF_FFFF,
                                        32'h8000_0000, 32'h7FFF_FFFF};

   hashed_key_value_store #(
      .BUCKETS(BUCKETS),
      .WAYS   (WAYS)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_lookup_key (req_lookup_key),
      .req_write_value(req_write_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_value (rsp_read_value),
      .rsp_key_found  (rsp_key_found),
      .rsp_status     (rsp_status)
   );

   hkv_access_checker #(
      .BUCKETS(BUCKETS),
      .WAYS   (WAYS)
   ) access_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_lookup_key (req_lookup_key),
      .req_write_value(req_write_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_value (rsp_read_value),
      .rsp_key_found  (rsp_key_found),
      .rsp_status     (rsp_status),
      .failures       (failures),
      .pending        (pending),
      .checked_count  (checked_count),
      .hit_count      (hit_count),
      .refused_count  (refused_count)
   );

   always #5 clock = ~clock;

   // Offer one item, wait for it to be taken, then idle at random.
   task automatic issue_access(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key,
                               input logic [VAL_W-1:0] wval);
      req_valid       <= 1'b1;
      req_action      <= act;
      req_lookup_key  <= key;
      req_write_value <= wval;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      issued++;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Stop offering and wait until every expected result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Keys crowd into the first four buckets so that buckets fill and keys repeat.
   task automatic refill_key_pool();
      logic [KEY_W-1:0] k;
      for (int n = 0; n < KEY_POOL; n++) begin
         k           = KEY_W'($urandom);
         key_pool[n] = k - KEY_W'(k % BUCKETS) + KEY_W'($urandom_range(3));
      end
   endtask

   task automatic random_access();
      logic [ACT_W-1:0] act;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] wval;
      int               pick;
      pick = $urandom_range(99);
      if (pick < 35)      act = hkv_pkg::ACT_READ;
      else if (pick < 70) act = hkv_pkg::ACT_WRITE;
      else if (pick < 94) act = hkv_pkg::ACT_ERASE;
      else                act = ACT_UNUSED;
      if ($urandom_range(99) < 88) key = key_pool[$urandom_range(KEY_POOL - 1)];
      else                         key = KEY_W'($urandom);
      if ($urandom_range(99) < 80) wval = $urandom;
      else                         wval = edge_values[$urandom_range(3)];
      issue_access(act, key, wval);
   endtask

   // Reset, directed corners, then random phases with different idling.
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Extreme keys and values, a full bucket, erase hit and miss, unused code.
      issue_access(hkv_pkg::ACT_READ,  '0, '0);
      issue_access(hkv_pkg::ACT_WRITE, '0, 32'h7FFF_FFFF);
      issue_access(hkv_pkg::ACT_READ,  '0, 32'hFFFF_FFFF);
      issue_access(hkv_pkg::ACT_WRITE, 31'h7FFF_FFFF, 32'h8000_0000);
      issue_access(hkv_pkg::ACT_READ,  31'h7FFF_FFFF, '0);
      issue_access(hkv_pkg::ACT_WRITE, KEY_W'(BUCKETS - 1 + BUCKETS), 32'hFFFF_FFFF);
      issue_access(hkv_pkg::ACT_WRITE, KEY_W'(BUCKETS - 1 + 2 * BUCKETS), 32'h5555_5555);
      issue_access(hkv_pkg::ACT_READ,  KEY_W'(BUCKETS - 1 + 3 * BUCKETS), 32'hAAAA_AAAA);
      issue_access(hkv_pkg::ACT_WRITE, KEY_W'(BUCKETS - 1 + 4 * BUCKETS), 32'h1234_5678);
      issue_access(hkv_pkg::ACT_READ,  KEY_W'(BUCKETS - 1 + 5 * BUCKETS), '0);
      issue_access(hkv_pkg::ACT_ERASE, KEY_W'(BUCKETS - 1 + BUCKETS), '0);
      issue_access(hkv_pkg::ACT_ERASE, KEY_W'(BUCKETS - 1 + BUCKETS), '0);
      issue_access(hkv_pkg::ACT_WRITE, KEY_W'(BUCKETS - 1 + 4 * BUCKETS), 32'h1234_5678);
      issue_access(ACT_UNUSED,         '0, 32'hDEAD_BEEF);
      issue_access(ACT_UNUSED,         31'h2AAA_AAAA, '0);
      issue_access(hkv_pkg::ACT_READ,  '0, '0);
      issue_access(hkv_pkg::ACT_ERASE, '0, '0);
      issue_access(hkv_pkg::ACT_READ,  '0, '0);
      issue_access(hkv_pkg::ACT_WRITE, 31'h4000_0000, 32'h0000_0001);
      drain_results();

      // Phases: no idling, sender idle, receiver stalling, both.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct <= 0;  end
            1: begin idle_pct = 70; stall_pct <= 0;  end
            2: begin idle_pct = 0;  stall_pct <= 70; end
            default: begin idle_pct = 37; stall_pct <= 37; end
         endcase
         refill_key_pool();
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // Long result hold-off while items keep coming, so the input backs up.
            if (phase == 0 && i == 30) hold_requests <= hold_requests + 1;
            random_access();
         end
         drain_results();
      end

      repeat (2 * WAYS + 12) @(posedge clock);
      $display("Run covered %0d accesses in directed corners and four idling phases,",
               issued);
      $display("with %0d results checked, %0d key hits and %0d bucket-full refusals.",
               checked_count, hit_count, refused_count);
      if (failures == 0 && pending == 0) begin
         $display("PASS hashed_key_value_store");
      end else begin
         $display("FAIL hashed_key_value_store");
      end
      $finish;
   end

   // Result side: random stalls, or a counted hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
         holds_served <= holds_served + 1;
         hold_left    <= HOLD_CYCLES;
         rsp_stall    <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Give up if the run hangs.
   initial begin
      #2_000_000;
      $display("FAIL hashed_key_value_store");
      $finish;
   end

endmodule

### files.f
rtl/hkv_pkg.sv
rtl/hkv_ram.sv
rtl/hkv_bucket_mod.sv
rtl/hashed_key_value_store.sv
verif/hkv_access_checker.sv
verif/tb_hashed_key_value_store.sv
